### design/tcl_pkg.sv
`timescale 1ns / 1ps

package tcl_pkg;

    // Default geometry of the cache and of the tile grid.
    localparam int TILE_DIM_DEF       = 256;
    localparam int CACHE_ENTRIES_DEF  = 16;
    localparam int TILE_GRID_COLS_DEF = 64;
    localparam int TILE_GRID_ROWS_DEF = 64;

    // Fixed widths of the interface fields.
    localparam int TILE_IDX_W = 16;
    localparam int SLOT_W     = 12;
    localparam int NSLOT_W    = 13;
    localparam int OFFSET_W   = 18;
    localparam logic [NSLOT_W-1:0] SLOT_LIMIT = 13'd4096;

    // Reset values of the configuration registers.
    localparam logic [14:0] PIC_WIDTH_RST    = 15'd16384;
    localparam logic [14:0] IMAGE_HEIGHT_RST = 15'd16384;
    localparam logic [2:0]  BPP_RST          = 3'd1;
    localparam logic [4:0]  MAX_ENTRIES_RST  = 5'd10;

    // Configuration register indexes.
    localparam logic [7:0] CFG_PIC_WIDTH    = 8'd0;
    localparam logic [7:0] CFG_IMAGE_HEIGHT = 8'd1;
    localparam logic [7:0] CFG_BPP          = 8'd2;
    localparam logic [7:0] CFG_MAX_ENTRIES  = 8'd3;

    typedef struct packed {
        logic        action;
        logic [13:0] pixel_x;
        logic [13:0] pixel_y;
    } tcl_in_t;

    typedef struct packed {
        logic        out_of_range;
        logic        hit;
        logic [3:0]  entry_index;
        logic [17:0] byte_offset;
        logic        evict_valid;
        logic [11:0] evicted_tile;
        logic        writeback;
        logic [11:0] writeback_slot;
        logic        fill_from_backing;
        logic [11:0] fill_slot;
    } tcl_out_t;

    typedef struct packed {
        logic [14:0] pic_width;
        logic [14:0] image_height;
        logic [2:0]  bytes_per_pixel;
        logic [4:0]  max_entries;
    } tcl_cfg_t;

    // Classified access as it travels from the front to the back.
    typedef struct packed {
        logic                  oor;
        logic                  action;
        logic [TILE_IDX_W-1:0] tile;
        logic [OFFSET_W-1:0]   offset;
    } tcl_item_t;

    // Control from the back to the front.
    typedef struct packed {
        logic pop;
        logic clearing;
    } tcl_back_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_T,
        ST_RD_V,
        ST_WR_T,
        ST_DONE
    } tcl_state_t;

endpackage

### design/tcl_ram.sv
`timescale 1ns / 1ps

module tcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/tcl_front.sv
`timescale 1ns / 1ps

module tcl_front #(
    parameter int TILE_DIM       = 256,
    parameter int TILE_GRID_COLS = 64,
    parameter int TILE_GRID_ROWS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcl_pkg::tcl_cfg_t     cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcl_pkg::tcl_in_t      in_data,
    output logic                  q_valid,
    output tcl_pkg::tcl_item_t    q_item,
    input  tcl_pkg::tcl_back_ctl_t back_ctl
);
    import tcl_pkg::*;

    localparam int DB = $clog2(TILE_DIM);

    logic [13:0]          tx;
    logic [13:0]          ty;
    logic [2*DB-1:0]      local_idx;
    logic [2:0]           bpp_eff;
    logic [OFFSET_W:0]    prod;
    tcl_item_t            item;
    tcl_item_t            q_mem_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 push;

    // Classify the access: tile, range check and byte offset.
    always_comb
    begin
        tx = in_data.pixel_x >> DB;
        ty = in_data.pixel_y >> DB;
        local_idx = {in_data.pixel_y[DB-1:0], in_data.pixel_x[DB-1:0]};
        if (cfg.bytes_per_pixel == 3'd0)
        begin
            bpp_eff = 3'd1;
        end
        else if (cfg.bytes_per_pixel > 3'd4)
        begin
            bpp_eff = 3'd4;
        end
        else
        begin
            bpp_eff = cfg.bytes_per_pixel;
        end
        prod = (OFFSET_W+1)'(bpp_eff) * (OFFSET_W+1)'(local_idx);
        item.action = in_data.action;
        item.oor = ({1'b0, in_data.pixel_x} >= cfg.pic_width)
                || ({1'b0, in_data.pixel_y} >= cfg.image_height)
                || (32'(tx) >= TILE_GRID_COLS)
                || (32'(ty) >= TILE_GRID_ROWS);
        item.tile = TILE_IDX_W'(32'(ty) * TILE_GRID_COLS + 32'(tx));
        item.offset = item.oor ? '0 : prod[OFFSET_W-1:0];
    end

    // Two-entry queue toward the back.
    assign in_ready = (count_reg != 2'd2) && !back_ctl.clearing;
    assign push = in_valid && in_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ back_ctl.pop;
        count_next = count_reg + 2'(push) - 2'(back_ctl.pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/tcl_back.sv
`timescale 1ns / 1ps

module tcl_back #(
    parameter int CACHE_ENTRIES  = 16,
    parameter int TILE_GRID_COLS = 64,
    parameter int TILE_GRID_ROWS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcl_pkg::tcl_cfg_t      cfg,
    input  logic                   q_valid,
    input  tcl_pkg::tcl_item_t     q_item,
    output tcl_pkg::tcl_back_ctl_t back_ctl,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tcl_pkg::tcl_out_t      out_data
);
    import tcl_pkg::*;

    localparam int TILE_COUNT = TILE_GRID_COLS * TILE_GRID_ROWS;
    localparam int TW  = TILE_COUNT > 1 ? $clog2(TILE_COUNT) : 1;
    localparam int EW  = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW  = $clog2(CACHE_ENTRIES + 1);
    localparam int TWW = 3 + EW + SLOT_W;
    localparam int P_RES   = 0;
    localparam int P_DIRTY = 1;
    localparam int P_BACK  = 2;
    localparam int P_ENTRY = 3;
    localparam int P_SLOT  = 3 + EW;

    tcl_state_t         state_reg;
    tcl_state_t         state_next;
    tcl_item_t          item_reg;
    tcl_item_t          item_next;
    tcl_out_t           res_reg;
    tcl_out_t           res_next;
    tcl_out_t           out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [TW-1:0]      clr_cnt_reg;
    logic [TW-1:0]      clr_cnt_next;
    logic [CW-1:0]      in_use_reg;
    logic [CW-1:0]      in_use_next;
    logic [NSLOT_W-1:0] nslot_reg;
    logic [NSLOT_W-1:0] nslot_next;
    logic [EW-1:0]      lru_reg [CACHE_ENTRIES];
    logic [EW-1:0]      lru_next [CACHE_ENTRIES];
    logic [EW-1:0]      e_reg;
    logic [EW-1:0]      e_next;
    logic [TWW-1:0]     ts_reg;
    logic [TWW-1:0]     ts_next;
    logic [TW-1:0]      v_reg;
    logic [TW-1:0]      v_next;
    logic [CW-1:0]      cap;
    logic               load_out;

    // Memory ports.
    logic               t_we;
    logic [TW-1:0]      t_waddr;
    logic [TWW-1:0]     t_wdata;
    logic [TW-1:0]      t_raddr;
    logic [TWW-1:0]     t_rdata;
    logic               o_we;
    logic [EW-1:0]      o_waddr;
    logic [TW-1:0]      o_rdata;

    // LRU update requests.
    logic               mru_en;
    logic               alloc_en;
    logic [EW-1:0]      upd_e;
    logic               match [CACHE_ENTRIES];
    logic               ge [CACHE_ENTRIES];

    // Derived status of the current access.
    logic               is_hit;
    logic               can_alloc;
    logic [EW-1:0]      sel_e;
    logic               v_backed;
    logic [SLOT_W-1:0]  v_slot;
    logic               v_wb;
    logic               take_slot;

    tcl_ram #(.WIDTH(TWW), .DEPTH(TILE_COUNT)) u_tile_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    tcl_ram #(.WIDTH(TW), .DEPTH(CACHE_ENTRIES)) u_owner_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (item_reg.tile[TW-1:0]),
        .raddr (lru_reg[0]),
        .rdata (o_rdata)
    );

    // Effective entry limit.
    always_comb
    begin
        if (cfg.max_entries == 5'd0)
        begin
            cap = CW'(1);
        end
        else if (32'(cfg.max_entries) > CACHE_ENTRIES)
        begin
            cap = CW'(CACHE_ENTRIES);
        end
        else
        begin
            cap = CW'(cfg.max_entries);
        end
    end

    assign is_hit = t_rdata[P_RES];
    assign can_alloc = (in_use_reg < cap);
    assign load_out = !out_valid_reg || out_ready;

    always_comb
    begin
        if (is_hit)
        begin
            sel_e = t_rdata[P_ENTRY +: EW];
        end
        else if (can_alloc)
        begin
            sel_e = EW'(in_use_reg);
        end
        else
        begin
            sel_e = lru_reg[0];
        end
    end

    // Victim write-back decision.
    always_comb
    begin
        take_slot = t_rdata[P_DIRTY] && !t_rdata[P_BACK] && (nslot_reg < SLOT_LIMIT);
        v_backed = t_rdata[P_BACK] || take_slot;
        v_slot = take_slot ? nslot_reg[SLOT_W-1:0] : t_rdata[P_SLOT +: SLOT_W];
        v_wb = t_rdata[P_DIRTY] && v_backed;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == TW'(TILE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.oor ? ST_DONE : ST_RD_T;
                end
            end
            ST_RD_T:
            begin
                state_next = (is_hit || can_alloc) ? ST_DONE : ST_RD_V;
            end
            ST_RD_V:
            begin
                state_next = ST_WR_T;
            end
            ST_WR_T:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls for each state.
    always_comb
    begin
        item_next = item_reg;
        res_next = res_reg;
        e_next = e_reg;
        ts_next = ts_reg;
        v_next = v_reg;
        clr_cnt_next = clr_cnt_reg;
        in_use_next = in_use_reg;
        nslot_next = nslot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        back_ctl.pop = 1'b0;
        back_ctl.clearing = 1'b0;
        t_we = 1'b0;
        t_waddr = item_reg.tile[TW-1:0];
        t_wdata = '0;
        t_raddr = item_reg.tile[TW-1:0];
        o_we = 1'b0;
        o_waddr = e_reg;
        mru_en = 1'b0;
        alloc_en = 1'b0;
        upd_e = e_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                back_ctl.clearing = 1'b1;
                t_we = 1'b1;
                t_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + TW'(1);
            end
            ST_IDLE:
            begin
                t_raddr = q_item.tile[TW-1:0];
                if (q_valid)
                begin
                    back_ctl.pop = 1'b1;
                    item_next = q_item;
                    res_next = '0;
                    res_next.out_of_range = q_item.oor;
                    res_next.byte_offset = q_item.offset;
                end
            end
            ST_RD_T:
            begin
                t_raddr = o_rdata;
                e_next = sel_e;
                ts_next = t_rdata;
                v_next = o_rdata;
                res_next.entry_index = 4'(sel_e);
                if (is_hit)
                begin
                    // Hit: refresh the entry and the dirty mark.
                    res_next.hit = 1'b1;
                    t_we = 1'b1;
                    t_wdata = t_rdata;
                    t_wdata[P_DIRTY] = t_rdata[P_DIRTY] || item_reg.action;
                    mru_en = 1'b1;
                    upd_e = sel_e;
                end
                else if (can_alloc)
                begin
                    // Miss with a free entry.
                    t_we = 1'b1;
                    t_wdata = t_rdata;
                    t_wdata[P_RES] = 1'b1;
                    t_wdata[P_DIRTY] = t_rdata[P_DIRTY] || item_reg.action;
                    t_wdata[P_ENTRY +: EW] = sel_e;
                    alloc_en = 1'b1;
                    upd_e = sel_e;
                    o_waddr = sel_e;
                    in_use_next = in_use_reg + CW'(1);
                    res_next.fill_from_backing = t_rdata[P_BACK];
                    res_next.fill_slot = t_rdata[P_BACK] ? t_rdata[P_SLOT +: SLOT_W] : '0;
                end
            end
            ST_RD_V:
            begin
                // Release the victim; write back if dirty with a slot.
                t_we = 1'b1;
                t_waddr = v_reg;
                t_wdata = t_rdata;
                t_wdata[P_RES] = 1'b0;
                t_wdata[P_DIRTY] = 1'b0;
                t_wdata[P_BACK] = v_backed;
                t_wdata[P_SLOT +: SLOT_W] = v_slot;
                if (take_slot)
                begin
                    nslot_next = nslot_reg + NSLOT_W'(1);
                end
                res_next.evict_valid = 1'b1;
                res_next.evicted_tile = 12'(v_reg);
                res_next.writeback = v_wb;
                res_next.writeback_slot = v_wb ? v_slot : '0;
            end
            ST_WR_T:
            begin
                // Install the missed tile in the evicted entry.
                t_we = 1'b1;
                t_wdata = ts_reg;
                t_wdata[P_RES] = 1'b1;
                t_wdata[P_DIRTY] = ts_reg[P_DIRTY] || item_reg.action;
                t_wdata[P_ENTRY +: EW] = e_reg;
                mru_en = 1'b1;
                res_next.fill_from_backing = ts_reg[P_BACK];
                res_next.fill_slot = ts_reg[P_BACK] ? ts_reg[P_SLOT +: SLOT_W] : '0;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        o_we = alloc_en || (state_reg == ST_WR_T);
    end

    // Recency list: move an entry to the tail or append a new one.
    always_comb
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            match[i] = (CW'(i) < in_use_reg) && (lru_reg[i] == upd_e);
        end
        ge[0] = match[0];
        for (int i = 1; i < CACHE_ENTRIES; i++)
        begin
            ge[i] = ge[i-1] || match[i];
        end
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            lru_next[i] = lru_reg[i];
            if (mru_en && ge[i])
            begin
                if (CW'(i + 1) == in_use_reg)
                begin
                    lru_next[i] = upd_e;
                end
                else if (i < CACHE_ENTRIES - 1)
                begin
                    lru_next[i] = lru_reg[(i < CACHE_ENTRIES - 1) ? i + 1 : i];
                end
            end
            if (alloc_en && (CW'(i) == in_use_reg))
            begin
                lru_next[i] = upd_e;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg <= res_next;
        e_reg <= e_next;
        ts_reg <= ts_next;
        v_reg <= v_next;
        if (state_reg == ST_DONE && load_out)
        begin
            out_reg <= res_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            in_use_reg <= '0;
            nslot_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                lru_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            in_use_reg <= in_use_next;
            nslot_reg <= nslot_next;
            out_valid_reg <= out_valid_next;
            lru_reg <= lru_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

### design/tile_cache_lru_controller_unit.sv
`timescale 1ns / 1ps
// Tile cache controller with least-recently-used replacement and write-back.
// Input channel (in_valid/in_ready/in_data): one pixel read or write access
// per transfer. Output channel (out_valid/out_ready/out_data): one result per
// access, in order: hit, cache entry, byte offset, eviction, write-back and
// fill information, or out_of_range for coordinates outside the image.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes image
// width, image height, bytes per pixel and the entry limit; it is always ready.
// The user must write it only while no access is in flight; the block itself
// does not enforce this. After reset the tile table is swept clear, one tile
// per cycle, over all TILE_GRID_COLS * TILE_GRID_ROWS tiles (4096 by default);
// in_ready stays low during the sweep.
// A front stage classifies each access and places it in a two-entry queue; a
// back sequencer runs each access against the tile table, a RAM with one
// write port and one registered read port. The back handles each access in
// steps: queue pop and tile read; tile update or victim read; victim write;
// tile write; result. An out-of-range access goes from the pop to the result,
// and a hit or a miss into a free entry skips the victim write and tile write.
// The back pops the next access only after the last result is registered.
// Results are held in an output register; a stalled receiver holds the back,
// while the front keeps queueing up to two accesses.
module tile_cache_lru_controller_unit #(
    parameter int TILE_DIM       = tcl_pkg::TILE_DIM_DEF,
    parameter int CACHE_ENTRIES  = tcl_pkg::CACHE_ENTRIES_DEF,
    parameter int TILE_GRID_COLS = tcl_pkg::TILE_GRID_COLS_DEF,
    parameter int TILE_GRID_ROWS = tcl_pkg::TILE_GRID_ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcl_pkg::tcl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tcl_pkg::tcl_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [14:0]       cfg_data
);
    import tcl_pkg::*;

    tcl_cfg_t      cfg_reg;
    tcl_cfg_t      cfg_next;
    logic          q_valid;
    tcl_item_t     q_item;
    tcl_back_ctl_t back_ctl;

    // Configuration register writes.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PIC_WIDTH:    cfg_next.pic_width = cfg_data;
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                CFG_BPP:          cfg_next.bytes_per_pixel = cfg_data[2:0];
                CFG_MAX_ENTRIES:  cfg_next.max_entries = cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pic_width <= PIC_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.bytes_per_pixel <= BPP_RST;
            cfg_reg.max_entries <= MAX_ENTRIES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcl_front #(
        .TILE_DIM       (TILE_DIM),
        .TILE_GRID_COLS (TILE_GRID_COLS),
        .TILE_GRID_ROWS (TILE_GRID_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .back_ctl (back_ctl)
    );

    tcl_back #(
        .CACHE_ENTRIES  (CACHE_ENTRIES),
        .TILE_GRID_COLS (TILE_GRID_COLS),
        .TILE_GRID_ROWS (TILE_GRID_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .back_ctl  (back_ctl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### tb/sv/tile_cache_lru_controller_unit_test.sv
`timescale 1ns / 1ps

module tile_cache_lru_controller_unit_test;
    import tcl_pkg::*;

    localparam int TILE_SIDE   = 256;
    localparam int GRID_SIDE   = 64;
    localparam int TILE_TOTAL  = GRID_SIDE * GRID_SIDE;
    localparam int ENTRY_COUNT = 16;
    localparam int SLOT_CAP    = 4096;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int POOL_SIZE   = 24;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    tcl_in_t     in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    tcl_out_t    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [14:0] cfg_data;

    tile_cache_lru_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the tile table and the replacement state.
    bit          tile_resident [TILE_TOTAL];
    bit          tile_dirty    [TILE_TOTAL];
    bit          tile_backed   [TILE_TOTAL];
    int          tile_entry    [TILE_TOTAL];
    int          tile_slot     [TILE_TOTAL];
    int          entry_tile    [ENTRY_COUNT];
    int          lru_list      [ENTRY_COUNT];
    int          used_entries;
    int          next_slot;

    // Shadow copy of the configuration registers.
    int          img_width  = 16384;
    int          img_height = 16384;
    int          pixel_bytes = 1;
    int          entry_limit = 10;

    tcl_out_t    pending_results [$];
    int          mismatch_count;
    int          cycle_count;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          tile_pool [POOL_SIZE];

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Move an entry to the most recently used end of the list.
    function automatic void promote_entry(int e);
        int pos;
        pos = used_entries;
        for (int i = 0; i < used_entries; i++)
        begin
            if (lru_list[i] == e && pos == used_entries)
                pos = i;
        end
        if (pos < used_entries)
        begin
            for (int i = pos; i + 1 < used_entries; i++)
                lru_list[i] = lru_list[i + 1];
            lru_list[used_entries - 1] = e;
        end
    endfunction

    // Work out the result of one access and update the shadow state.
    function automatic tcl_out_t predict_access(tcl_in_t a);
        tcl_out_t r;
        int tx, ty, t, e, v, bpp, cap;
        r = '0;
        tx = a.pixel_x / TILE_SIDE;
        ty = a.pixel_y / TILE_SIDE;
        if (a.pixel_x >= img_width || a.pixel_y >= img_height ||
            tx >= GRID_SIDE || ty >= GRID_SIDE)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        t = ty * GRID_SIDE + tx;
        bpp = (pixel_bytes < 1) ? 1 : ((pixel_bytes > 4) ? 4 : pixel_bytes);
        cap = (entry_limit < 1) ? 1 : ((entry_limit > ENTRY_COUNT) ? ENTRY_COUNT : entry_limit);

        if (tile_resident[t])
        begin
            r.hit = 1'b1;
            e = tile_entry[t];
            promote_entry(e);
        end
        else
        begin
            if (used_entries < cap)
            begin
                e = used_entries;
                lru_list[used_entries] = e;
                used_entries++;
            end
            else
            begin
                // Take the least recently used entry from its tile.
                e = lru_list[0] % ENTRY_COUNT;
                v = entry_tile[e] % TILE_TOTAL;
                r.evict_valid = 1'b1;
                r.evicted_tile = v[11:0];
                if (tile_dirty[v])
                begin
                    if (!tile_backed[v] && next_slot < SLOT_CAP)
                    begin
                        tile_backed[v] = 1'b1;
                        tile_slot[v] = next_slot;
                        next_slot++;
                    end
                    if (tile_backed[v])
                    begin
                        r.writeback = 1'b1;
                        r.writeback_slot = tile_slot[v][11:0];
                    end
                end
                tile_resident[v] = 1'b0;
                tile_dirty[v] = 1'b0;
                promote_entry(e);
            end
            entry_tile[e] = t;
            tile_resident[t] = 1'b1;
            tile_entry[t] = e;
            if (tile_backed[t])
            begin
                r.fill_from_backing = 1'b1;
                r.fill_slot = tile_slot[t][11:0];
            end
        end
        if (a.action)
            tile_dirty[t] = 1'b1;
        r.entry_index = e[3:0];
        r.byte_offset = 18'(bpp * ((a.pixel_y % TILE_SIDE) * TILE_SIDE + (a.pixel_x % TILE_SIDE)));
        return r;
    endfunction

    // Receiver side: random stalls, driven at the falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= snk_stall_pct);

    task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch in %s: expected %0d, got %0d", name, exp_v, act_v);
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        tcl_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result with no access outstanding: %h", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.out_of_range !== want.out_of_range)
                    report_field("out_of_range", want.out_of_range, out_data.out_of_range);
                if (out_data.hit !== want.hit)
                    report_field("hit", want.hit, out_data.hit);
                if (out_data.entry_index !== want.entry_index)
                    report_field("entry_index", want.entry_index, out_data.entry_index);
                if (out_data.byte_offset !== want.byte_offset)
                    report_field("byte_offset", want.byte_offset, out_data.byte_offset);
                if (out_data.evict_valid !== want.evict_valid)
                    report_field("evict_valid", want.evict_valid, out_data.evict_valid);
                if (out_data.evicted_tile !== want.evicted_tile)
                    report_field("evicted_tile", want.evicted_tile, out_data.evicted_tile);
                if (out_data.writeback !== want.writeback)
                    report_field("writeback", want.writeback, out_data.writeback);
                if (out_data.writeback_slot !== want.writeback_slot)
                    report_field("writeback_slot", want.writeback_slot, out_data.writeback_slot);
                if (out_data.fill_from_backing !== want.fill_from_backing)
                    report_field("fill_from_backing", want.fill_from_backing,
                                 out_data.fill_from_backing);
                if (out_data.fill_slot !== want.fill_slot)
                    report_field("fill_slot", want.fill_slot, out_data.fill_slot);
            end
        end
    end

    // Send one access; called and returning at a falling edge with valid left high.
    task automatic send_access(bit act, int x, int y);
        tcl_in_t item;
        item.action = act;
        item.pixel_x = x[13:0];
        item.pixel_y = y[13:0];
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_access(item));
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain_results;
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Write one configuration register; the block must be idle.
    task automatic write_reg(logic [7:0] idx, int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value[14:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PIC_WIDTH:    img_width = value & 32'h7FFF;
            CFG_IMAGE_HEIGHT: img_height = value & 32'h7FFF;
            CFG_BPP:          pixel_bytes = value & 32'h7;
            CFG_MAX_ENTRIES:  entry_limit = value & 32'h1F;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_config(int w, int h, int bpp, int cap);
        drain_results();
        write_reg(CFG_PIC_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_BPP, bpp);
        write_reg(CFG_MAX_ENTRIES, cap);
    endtask

    // Corners, hits, dirty evictions, refills, odd register values, bounds.
    task automatic test_directed;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_access(1'b0, 0, 0);
        send_access(1'b1, 16383, 16383);
        send_access(1'b0, 16383, 16383);
        send_access(1'b1, 255, 0);
        // One entry only: every miss evicts, dirty victims are written back.
        apply_config(16384, 16384, 4, 1);
        send_access(1'b1, 0, 256);
        send_access(1'b0, 0, 0);
        send_access(1'b0, 10, 300);
        send_access(1'b1, 12, 12);
        send_access(1'b0, 511, 511);
        send_access(1'b0, 5, 5);
        // Out-of-range limits: 0 acts as 1 entry, 7 bytes acts as 4.
        apply_config(16384, 16384, 0, 0);
        send_access(1'b1, 700, 700);
        send_access(1'b0, 255, 255);
        apply_config(16384, 16384, 7, 31);
        send_access(1'b1, 9000, 4000);
        send_access(1'b0, 255, 255);
        // Tiny image: one pixel inside, neighbors outside.
        apply_config(1, 1, 2, 16);
        send_access(1'b0, 0, 0);
        send_access(1'b1, 1, 0);
        send_access(1'b0, 0, 1);
        send_access(1'b1, 16383, 16383);
        apply_config(32767, 32767, 3, 2);
        send_access(1'b1, 16383, 0);
        send_access(1'b0, 0, 16383);
        send_access(1'b1, 8191, 8191);
        // Sender holds back until every result is in.
        drain_results();
        send_access(1'b0, 16383, 0);
        drain_results();
    endtask

    // One random phase under a fixed configuration and idling pattern.
    task automatic test_random_phase(int w, int h, int bpp, int cap, int src_pct,
                                     int snk_pct, int count);
        int eff_w, eff_h, r, k, x, y;
        apply_config(w, h, bpp, cap);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        eff_w = (w < 1) ? 1 : ((w > 16384) ? 16384 : w);
        eff_h = (h < 1) ? 1 : ((h > 16384) ? 16384 : h);
        for (int i = 0; i < POOL_SIZE; i++)
            tile_pool[i] = $urandom_range((eff_h - 1) / TILE_SIDE) * GRID_SIDE
                         + $urandom_range((eff_w - 1) / TILE_SIDE);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                x = $urandom_range(16383);
                y = $urandom_range(16383);
            end
            else if (r < 15)
            begin
                x = $urandom_range(16383, (eff_w > 16383) ? 16383 : eff_w);
                y = $urandom_range(16383);
            end
            else
            begin
                // Accesses within a small set of tiles, to force reuse and eviction.
                k = tile_pool[$urandom_range(POOL_SIZE - 1)];
                x = (k % GRID_SIDE) * TILE_SIDE + $urandom_range(255);
                y = (k / GRID_SIDE) * TILE_SIDE + $urandom_range(255);
                if (x >= eff_w)
                    x = eff_w - 1;
                if (y >= eff_h)
                    y = eff_h - 1;
            end
            send_access($urandom_range(1), x, y);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        used_entries = 0;
        next_slot = 0;
        foreach (tile_resident[i])
        begin
            tile_resident[i] = 1'b0;
            tile_dirty[i] = 1'b0;
            tile_backed[i] = 1'b0;
            tile_entry[i] = 0;
            tile_slot[i] = 0;
        end
        foreach (entry_tile[i])
        begin
            entry_tile[i] = 0;
            lru_list[i] = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_phase(16384, 16384, 1, 10, 0, 0, 180);
        test_random_phase(300, 700, 4, 16, 73, 0, 180);
        test_random_phase(16384, 16384, 2, 3, 0, 73, 180);
        test_random_phase(32767, 1, 7, 31, 10, 10, 180);
        test_random_phase(1000, 16384, 0, 0, 0, 0, 180);
        test_random_phase(2048, 1536, 3, 5, 73, 0, 180);
        test_random_phase(16384, 9000, 4, 16, 0, 73, 180);
        test_random_phase(5000, 5000, 1, 8, 10, 10, 180);
        drain_results();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
design/tcl_pkg.sv
design/tcl_ram.sv
design/tcl_front.sv
design/tcl_back.sv
design/tile_cache_lru_controller_unit.sv
tb/sv/tile_cache_lru_controller_unit_test.sv
